// ----- design/exponential_atmosphere_density_top_macros.svh -----
// Assertion macros for the exponential atmosphere density block.
// Needs i_clk and i_rst_n in the scope of each use.
`ifndef EXPONENTIAL_ATMOSPHERE_DENSITY_TOP_MACROS_SVH
`define EXPONENTIAL_ATMOSPHERE_DENSITY_TOP_MACROS_SVH

// same-cycle implication
`define EAD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define EAD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/ead_pkg.sv -----
// Shared widths, band constants, pipeline control type and the 2^x table builder.
// No dependencies.
package ead_pkg;

    localparam int H_W        = 22;
    localparam int D_W        = H_W + 1;
    localparam int K_W        = 21;
    localparam int L_W        = 23;
    localparam int P_W        = D_W + K_W + 1;
    localparam int Y_W        = P_W;
    localparam int F_W        = 32;
    localparam int E_W        = Y_W - F_W;
    localparam int X_W        = E_W + 1;
    localparam int M_W        = 31;
    localparam int OUT_W      = 32;
    localparam int NUM_BANDS  = 27;
    localparam int BAND_W     = 5;
    localparam int ROOT_COUNT = 12;
    localparam int LOG_SHIFT  = 16;
    localparam int EXP_BIAS   = 127;
    localparam int EXP_MAX    = 255;

    localparam logic [31:0] LN2_Q32        = 32'd2977044472;
    localparam logic [31:0] FLOAT_MAX_BITS = 32'h7F7F_FFFF;
    localparam logic [63:0] Q30_ONE        = 64'd1073741824;
    localparam logic [63:0] Q30_HALF       = 64'd536870912;

    localparam logic signed [H_W-1:0] BAND_HEIGHT [NUM_BANDS+1] = '{
        22'sd0,      22'sd25000,  22'sd30000,  22'sd40000,  22'sd50000,  22'sd60000,
        22'sd70000,  22'sd80000,  22'sd90000,  22'sd100000, 22'sd110000, 22'sd120000,
        22'sd130000, 22'sd140000, 22'sd150000, 22'sd180000, 22'sd200000, 22'sd250000,
        22'sd300000, 22'sd350000, 22'sd400000, 22'sd450000, 22'sd500000, 22'sd600000,
        22'sd700000, 22'sd800000, 22'sd900000, 22'sd1000000
    };

    localparam logic signed [L_W-1:0] BAND_LOG_RHO [NUM_BANDS] = '{
        23'sd19188,    -23'sd306758,  -23'sd381213,  -23'sd522710,  -23'sd647876,
        -23'sd760672,  -23'sd883233,  -23'sd1027595, -23'sd1190640, -23'sd1366316,
        -23'sd1527202, -23'sd1657388, -23'sd1757191, -23'sd1832018, -23'sd1890564,
        -23'sd2016498, -23'sd2080082, -23'sd2207490, -23'sd2311284, -23'sd2399435,
        -23'sd2488133, -23'sd2568923, -23'sd2646640, -23'sd2794785, -23'sd2926405,
        -23'sd3033038, -23'sd3108895
    };

    localparam logic [K_W-1:0] BAND_RATE [NUM_BANDS] = '{
        21'd854784,  21'd975953,  21'd927316,  21'd820271,  21'd739242,  21'd803257,
        21'd946149,  21'd1068517, 21'd1151306, 21'd1054335, 21'd853136,  21'd654104,
        21'd490371,  21'd383697,  21'd275111,  21'd208350,  21'd166994,  21'd136045,
        21'd115543,  21'd116258,  21'd105893,  21'd101866,  21'd97088,   21'd86258,
        21'd69883,   21'd49714,   21'd34224
    };

    localparam logic [31:0] ROOT_Q30 [ROOT_COUNT] = '{
        32'd1518500250, 32'd1276901417, 32'd1170923762, 32'd1121280436,
        32'd1097253708, 32'd1085434106, 32'd1079572136, 32'd1076653033,
        32'd1075196443, 32'd1074468888, 32'd1074105294, 32'd1073923544
    };

    typedef struct packed {
        logic valid;
        logic above;
    } t_ctl;

    // 2^(idx / 2^bits) in Q30, one rounded root product per set index bit
    function automatic logic [M_W-1:0] pow2_entry(input int idx, input int bits);
        logic [63:0] m;
        m = Q30_ONE;
        for (int k = 0; k < bits && k < ROOT_COUNT; k++) begin
            if (((idx >> (bits - 1 - k)) & 1) != 0) begin
                m = (m * {32'd0, ROOT_Q30[k]} + Q30_HALF) >> 30;
            end
        end
        return m[M_W-1:0];
    endfunction

endpackage

// ----- design/ead_band_sel.sv -----
// Band selection and offset from the band base height, two register stages.
// Depends on ead_pkg.
module ead_band_sel (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic signed [ead_pkg::H_W-1:0] i_altitude_m,
    output ead_pkg::t_ctl                 o_ctl,
    output logic signed [ead_pkg::D_W-1:0] o_d,
    output logic [ead_pkg::K_W-1:0]       o_rate,
    output logic signed [ead_pkg::L_W-1:0] o_log_rho
);
    import ead_pkg::*;

    t_ctl                    r_ctl1, n_ctl1, r_ctl2;
    logic [BAND_W-1:0]       r_band, n_band;
    logic signed [H_W-1:0]   r_h;
    logic signed [D_W-1:0]   r_d, n_d;
    logic [K_W-1:0]          r_rate;
    logic signed [L_W-1:0]   r_log_rho;

    always_comb begin
        n_band       = BAND_W'(NUM_BANDS - 1);
        n_ctl1.valid = i_valid;
        n_ctl1.above = 1'b1;
        for (int i = NUM_BANDS - 1; i >= 0; i--) begin
            if (i_altitude_m < BAND_HEIGHT[i+1]) begin
                n_band       = BAND_W'(i);
                n_ctl1.above = 1'b0;
            end
        end
    end

    assign n_d = $signed({r_h[H_W-1], r_h})
               - $signed({BAND_HEIGHT[r_band][H_W-1], BAND_HEIGHT[r_band]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
        end else begin
            r_ctl1 <= n_ctl1;
            r_ctl2 <= r_ctl1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h       <= i_altitude_m;
        r_band    <= n_band;
        r_d       <= n_d;
        r_rate    <= BAND_RATE[r_band];
        r_log_rho <= BAND_LOG_RHO[r_band];
    end

    assign o_ctl     = r_ctl2;
    assign o_d       = r_d;
    assign o_rate    = r_rate;
    assign o_log_rho = r_log_rho;

endmodule

// ----- design/ead_log_eval.sv -----
// Log2 of density: multiply offset by band rate, subtract from log2(rho0), split.
// Depends on ead_pkg.
module ead_log_eval (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ead_pkg::t_ctl                  i_ctl,
    input  logic signed [ead_pkg::D_W-1:0] i_d,
    input  logic [ead_pkg::K_W-1:0]        i_rate,
    input  logic signed [ead_pkg::L_W-1:0] i_log_rho,
    output ead_pkg::t_ctl                  o_ctl,
    output logic signed [ead_pkg::E_W-1:0] o_e,
    output logic [ead_pkg::F_W-1:0]        o_frac
);
    import ead_pkg::*;

    t_ctl                  r_ctl1, r_ctl2;
    logic signed [P_W-1:0] r_p, n_p;
    logic signed [L_W-1:0] r_log_rho;
    logic signed [Y_W-1:0] w_lsh, w_y;
    logic signed [E_W-1:0] r_e;
    logic [F_W-1:0]        r_frac;

    assign n_p   = i_d * $signed({1'b0, i_rate});
    assign w_lsh = {{(Y_W - L_W - LOG_SHIFT){r_log_rho[L_W-1]}}, r_log_rho, LOG_SHIFT'(0)};
    assign w_y   = w_lsh - r_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
        end else begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p       <= n_p;
        r_log_rho <= i_log_rho;
        r_e       <= w_y[Y_W-1:F_W];
        r_frac    <= w_y[F_W-1:0];
    end

    assign o_ctl  = r_ctl2;
    assign o_e    = r_e;
    assign o_frac = r_frac;

endmodule

// ----- design/ead_pow2.sv -----
// 2^fraction by table and linear correction, rounding and single-precision packing.
// Depends on ead_pkg.
module ead_pow2 #(
    parameter int EXP_TABLE_BITS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ead_pkg::t_ctl                  i_ctl,
    input  logic signed [ead_pkg::E_W-1:0] i_e,
    input  logic [ead_pkg::F_W-1:0]        i_frac,
    output logic                           o_valid,
    output logic [ead_pkg::OUT_W-1:0]      o_density_bits,
    output logic                           o_above_limit
);
    import ead_pkg::*;

    localparam int RW          = F_W - EXP_TABLE_BITS;
    localparam int TABLE_DEPTH = 2 ** EXP_TABLE_BITS;
    localparam int MC_W        = M_W + RW;

    logic [M_W-1:0]        w_tab [TABLE_DEPTH];
    t_ctl                  r_ctl1, r_ctl2, r_ctl3, r_ctl4;
    logic [M_W-1:0]        r_t1, r_t2;
    logic [RW-1:0]         r_c;
    logic [RW+31:0]        w_cprod;
    logic signed [E_W-1:0] r_e1, r_e2;
    logic [MC_W-1:0]       r_mc;
    logic [MC_W:0]         w_rnd;
    logic [31:0]           w_m;
    logic [32:0]           w_m64;
    logic [25:0]           w_q;
    logic                  w_big;
    logic [22:0]           r_mant, n_mant;
    logic signed [X_W-1:0] r_be, n_be;
    logic [OUT_W-1:0]      r_density, n_density;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_tab
        localparam logic [M_W-1:0] ENTRY = pow2_entry(g, EXP_TABLE_BITS);
        assign w_tab[g] = ENTRY;
    end

    assign w_cprod = {32'd0, i_frac[RW-1:0]} * {RW'(0), LN2_Q32};
    assign w_rnd   = {1'b0, r_mc} + (MC_W + 1)'(64'd2147483648);
    assign w_m     = 32'(r_t2) + 32'(w_rnd[MC_W:32]);
    assign w_m64   = {1'b0, w_m} + 33'd64;
    assign w_q     = w_m64[32:7];
    assign w_big   = w_q[25] | w_q[24];
    assign n_mant  = w_big ? w_q[23:1] : w_q[22:0];
    assign n_be    = $signed({r_e2[E_W-1], r_e2}) + $signed(X_W'(EXP_BIAS))
                   + $signed({{(X_W - 1){1'b0}}, w_big});

    always_comb begin
        if (r_ctl3.above) begin
            n_density = '0;
        end else if (r_be >= $signed(X_W'(EXP_MAX))) begin
            n_density = FLOAT_MAX_BITS;
        end else if (r_be <= $signed(X_W'(0))) begin
            n_density = '0;
        end else begin
            n_density = {1'b0, r_be[7:0], r_mant};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
            r_ctl3 <= '0;
            r_ctl4 <= '0;
        end else begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
            r_ctl3 <= r_ctl2;
            r_ctl4 <= r_ctl3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t1      <= w_tab[i_frac[F_W-1 -: EXP_TABLE_BITS]];
        r_c       <= w_cprod[RW+31:32];
        r_e1      <= i_e;
        r_mc      <= {{RW{1'b0}}, r_t1} * {{M_W{1'b0}}, r_c};
        r_t2      <= r_t1;
        r_e2      <= r_e1;
        r_mant    <= n_mant;
        r_be      <= n_be;
        r_density <= n_density;
    end

    assign o_valid        = r_ctl4.valid;
    assign o_above_limit  = r_ctl4.above;
    assign o_density_bits = r_density;

endmodule

// ----- design/exponential_atmosphere_density_top.sv -----
// One transfer per cycle sustained; busy is always low. Eight register stages: band select,
// offset, rate multiply, log subtract, table read, correction multiply, rounding, packing.
// Reset (synchronous, active low) clears every valid bit; items in flight are dropped.
// Depends on ead_pkg, ead_band_sel, ead_log_eval, ead_pow2 and the assertion macros.
`include "exponential_atmosphere_density_top_macros.svh"

module exponential_atmosphere_density_top #(
    parameter int EXP_TABLE_BITS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [ead_pkg::H_W-1:0] i_altitude_m,
    output logic                           o_valid,
    output logic [ead_pkg::OUT_W-1:0]      o_density_bits,
    output logic                           o_above_limit
);
    import ead_pkg::*;

    t_ctl                  w_band_ctl, w_log_ctl;
    logic signed [D_W-1:0] w_d;
    logic [K_W-1:0]        w_rate;
    logic signed [L_W-1:0] w_log_rho;
    logic signed [E_W-1:0] w_e;
    logic [F_W-1:0]        w_frac;

    assign busy = 1'b0;

    ead_band_sel u_band_sel (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (start && !busy),
        .i_altitude_m (i_altitude_m),
        .o_ctl        (w_band_ctl),
        .o_d          (w_d),
        .o_rate       (w_rate),
        .o_log_rho    (w_log_rho)
    );

    ead_log_eval u_log_eval (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_band_ctl),
        .i_d       (w_d),
        .i_rate    (w_rate),
        .i_log_rho (w_log_rho),
        .o_ctl     (w_log_ctl),
        .o_e       (w_e),
        .o_frac    (w_frac)
    );

    ead_pow2 #(
        .EXP_TABLE_BITS (EXP_TABLE_BITS)
    ) u_pow2 (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (w_log_ctl),
        .i_e            (w_e),
        .i_frac         (w_frac),
        .o_valid        (o_valid),
        .o_density_bits (o_density_bits),
        .o_above_limit  (o_above_limit)
    );

    `EAD_ASSERT_IMPL(a_result_has_item, o_valid, $past(start && !busy, 8), "result without transfer")
    `EAD_ASSERT_IMPL(a_above_is_zero, o_valid && o_above_limit, o_density_bits == '0, "above limit not zero")
    `EAD_ASSERT_IMPL(a_sign_clear, o_valid, !o_density_bits[OUT_W-1], "negative density")
    `EAD_ASSERT_NEXT(a_item_gives_result, start && !busy, ##7 o_valid, "transfer without result")

endmodule

// ----- tb/sv/exponential_atmosphere_density_top_test.sv -----
`timescale 1ns / 100ps
// Self-checking bench for exponential_atmosphere_density_top: altitude in, density out.
// Holds its own band tables and log2-domain density predictor; needs only ead_pkg and the RTL.
module exponential_atmosphere_density_top_test;

    localparam int EXP_TABLE_BITS = 8;
    localparam int STALL_LIMIT    = 2000;
    localparam int RANDOM_ITEMS   = 1130;

    class density_scoreboard #(int TABLE_BITS = 8);

        typedef struct {
            logic signed [21:0] altitude;
            logic [31:0]        bits;
            logic               above;
            bit                 carried;
        } t_density;

        longint   floor_m[28];
        longint   log_rho[27];
        longint   rate[27];
        longint   roots[12];
        longint   pow2_q30[1 << TABLE_BITS];
        t_density pending[$];
        int       errors;
        int       checked;
        int       above_seen;
        int       saturated;
        int       carried;

        function new();
            longint m;
            floor_m = '{0, 25000, 30000, 40000, 50000, 60000, 70000, 80000, 90000, 100000,
                        110000, 120000, 130000, 140000, 150000, 180000, 200000, 250000,
                        300000, 350000, 400000, 450000, 500000, 600000, 700000, 800000,
                        900000, 1000000};
            log_rho = '{19188, -306758, -381213, -522710, -647876, -760672, -883233,
                        -1027595, -1190640, -1366316, -1527202, -1657388, -1757191,
                        -1832018, -1890564, -2016498, -2080082, -2207490, -2311284,
                        -2399435, -2488133, -2568923, -2646640, -2794785, -2926405,
                        -3033038, -3108895};
            rate = '{854784, 975953, 927316, 820271, 739242, 803257, 946149, 1068517,
                     1151306, 1054335, 853136, 654104, 490371, 383697, 275111, 208350,
                     166994, 136045, 115543, 116258, 105893, 101866, 97088, 86258,
                     69883, 49714, 34224};
            roots = '{1518500250, 1276901417, 1170923762, 1121280436, 1097253708,
                      1085434106, 1079572136, 1076653033, 1075196443, 1074468888,
                      1074105294, 1073923544};
            // build 2^(idx/2^bits) in Q30, most significant index bit first
            for (int idx = 0; idx < (1 << TABLE_BITS); idx++) begin
                m = 64'd1 << 30;
                for (int k = 0; k < TABLE_BITS && k < 12; k++) begin
                    if (((idx >> (TABLE_BITS - 1 - k)) & 1) != 0) begin
                        m = (m * roots[k] + (64'd1 << 29)) >> 30;
                    end
                end
                pow2_q30[idx] = m;
            end
            errors     = 0;
            checked    = 0;
            above_seen = 0;
            saturated  = 0;
            carried    = 0;
        endfunction

        function t_density predict(logic signed [21:0] alt);
            t_density r;
            longint   h;
            longint   y;
            longint   yb;
            longint   e;
            longint   frac;
            longint   m;
            longint   c;
            longint   q;
            int       band;
            h         = alt;
            band      = -1;
            r.altitude = alt;
            r.carried  = 1'b0;
            for (int i = 0; i < 27; i++) begin
                if (band < 0 && h < floor_m[i+1]) begin
                    band = i;
                end
            end
            if (band < 0) begin
                r.bits  = '0;
                r.above = 1'b1;
                return r;
            end
            r.above = 1'b0;
            y    = log_rho[band] * 65536 - (h - floor_m[band]) * rate[band];
            yb   = y + (longint'(1024) << 32);
            e    = (yb >> 32) - 1024;
            frac = yb & 64'hFFFF_FFFF;
            m    = pow2_q30[frac >> (32 - TABLE_BITS)];
            c    = ((frac & ((64'd1 << (32 - TABLE_BITS)) - 1)) * 64'd2977044472) >> 32;
            m    = m + ((m * c + 64'd2147483648) >> 32);
            q    = (m + 64) >> 7;
            if (q >= (64'd1 << 24)) begin
                q         = q >> 1;
                e         = e + 1;
                r.carried = 1'b1;
            end
            if (e + 127 >= 255) begin
                r.bits = 32'h7F7F_FFFF;
            end else if (e + 127 <= 0) begin
                r.bits = '0;
            end else begin
                r.bits = {9'(e + 127), q[22:0]};
            end
            return r;
        endfunction

        function void note(logic signed [21:0] alt);
            pending.push_back(predict(alt));
        endfunction

        function void check(logic [31:0] bits, logic above);
            t_density x;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result density %h above %b", $time, bits, above);
                errors++;
                return;
            end
            x = pending.pop_front();
            checked++;
            if (x.above) above_seen++;
            if (x.bits == 32'h7F7F_FFFF) saturated++;
            if (x.carried) carried++;
            if (bits !== x.bits) begin
                $display("%0t: altitude %0d density expected %h actual %h",
                         $time, x.altitude, x.bits, bits);
                errors++;
            end
            if (above !== x.above) begin
                $display("%0t: altitude %0d above_limit expected %b actual %b",
                         $time, x.altitude, x.above, above);
                errors++;
            end
        endfunction

    endclass

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                start;
    logic                                busy;
    logic signed [ead_pkg::H_W-1:0]      i_altitude_m;
    logic                                o_valid;
    logic [ead_pkg::OUT_W-1:0]           o_density_bits;
    logic                                o_above_limit;

    density_scoreboard #(EXP_TABLE_BITS) sb;
    int                                  stall_cycles;
    int                                  sent;

    exponential_atmosphere_density_top #(
        .EXP_TABLE_BITS(EXP_TABLE_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_altitude_m   (i_altitude_m),
        .o_valid        (o_valid),
        .o_density_bits (o_density_bits),
        .o_above_limit  (o_above_limit)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    task automatic send_altitude(input logic signed [21:0] alt);
        @(negedge i_clk);
        start        <= 1'b1;
        i_altitude_m <= alt;
        do @(posedge i_clk); while (busy);
        sb.note(alt);
        sent++;
    endtask

    task automatic hold_off(input int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (cycles - 1) @(posedge i_clk);
        end
    endtask

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [21:0] draw_altitude();
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            v = int'($urandom_range(0, 2100000)) - 100000;
        end else if (r < 65) begin
            v = int'($urandom_range(0, 100000));
        end else if (r < 85) begin
            v = int'(sb.floor_m[$urandom_range(0, 27)]) + int'($urandom_range(0, 6)) - 3;
        end else begin
            v = int'($urandom());
        end
        return 22'(v);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            sb.check(o_density_bits, o_above_limit);
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy && i_rst_n) || o_valid) begin
            stall_cycles = 0;
        end else begin
            stall_cycles = stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
            $display("exponential_atmosphere_density_top_test failed");
            $finish;
        end
    end

    initial begin
        logic signed [21:0]                             directed[$];
        logic signed [21:0]                             carry_alt;
        bit                                             steady;
        density_scoreboard #(EXP_TABLE_BITS)::t_density probe;
        sb           = new();
        stall_cycles = 0;
        sent         = 0;
        steady       = 1'b0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_altitude_m = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        directed = '{-22'sd2097152, 22'sd2097151, -22'sd100000, -22'sd641700,
                     -22'sd641600, -22'sd1, 22'sd0, 22'sd1, 22'sd24999, 22'sd25000,
                     22'sd29999, 22'sd30000, 22'sd149999, 22'sd150000, 22'sd500000,
                     22'sd899999, 22'sd900000, 22'sd999999, 22'sd1000000, 22'sd1000001,
                     22'sd2000000, 22'sd1048575, -22'sd1048576};
        // add one altitude whose mantissa rounds up into the next binade
        for (int h = 0; h < 25000; h++) begin
            probe = sb.predict(22'(h));
            if (probe.carried) begin
                carry_alt = 22'(h);
                directed.push_back(carry_alt);
                break;
            end
        end
        foreach (directed[i]) begin
            send_altitude(directed[i]);
            if (i % 5 == 4) hold_off(i % 3 + 1);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(0, 39) == 0) steady = !steady;
            if (!steady) hold_off(draw_gap());
            send_altitude(draw_altitude());
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Sent %0d altitudes, checked %0d densities: %0d above limit, %0d saturated,",
                 sent, sb.checked, sb.above_seen, sb.saturated);
        $display("%0d with mantissa carry, %0d mismatches.", sb.carried, sb.errors);
        if (sb.errors == 0) begin
            $display("exponential_atmosphere_density_top_test passed");
        end else begin
            $display("exponential_atmosphere_density_top_test failed");
        end
        $finish;
    end

endmodule
